// ----- hdl/dtcsl_pkg.sv -----
// ============================================================================
// dtcsl_pkg - shared types and constants for the troubled-cell slope limiter
// Item layouts, register map, config bundle and fixed-point constants.
// ============================================================================
`default_nettype none

package dtcsl_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;

    // Register widths
    localparam int GAIN_W = 21;
    localparam int THR_W  = 17;
    localparam int TOL_W  = 17;

    // APB register map: register i at byte address 4*i
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_TVB_GAIN   = 2'd0;
    localparam logic [1:0] REG_IND_THRESH = 2'd1;
    localparam logic [1:0] REG_CHG_TOL    = 2'd2;

    // Reset values (Q16.16)
    localparam logic [GAIN_W-1:0] GAIN_RST = 21'd65536;
    localparam logic [THR_W-1:0]  THR_RST  = 17'd6554;
    localparam logic [TOL_W-1:0]  TOL_RST  = 17'd0;

    // Unsigned Q2.30 constants
    localparam logic [31:0] K_TWO_SQRT3     = 32'd3719550787;
    localparam logic [31:0] K_FIVE_SQRT5_3  = 32'd4001599515;
    localparam logic [29:0] K_INV_SQRT3     = 30'd619925131;

    typedef struct packed {
        logic [GAIN_W-1:0] tvb_gain;
        logic [THR_W-1:0]  indicator_threshold;
        logic [TOL_W-1:0]  change_tolerance;
    } t_cfg;

    typedef struct packed {
        logic signed [WORD_W-1:0] left_mean;
        logic signed [WORD_W-1:0] left_slope;
        logic signed [WORD_W-1:0] left_curv;
        logic signed [WORD_W-1:0] cell_mean;
        logic signed [WORD_W-1:0] cell_slope;
        logic signed [WORD_W-1:0] cell_curv;
        logic signed [WORD_W-1:0] right_mean;
        logic signed [WORD_W-1:0] right_slope;
        logic signed [WORD_W-1:0] right_curv;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] slope_out;
        logic signed [WORD_W-1:0] curv_out;
        logic                     troubled;
        logic                     limited;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hdl/dtcsl_apb_regs.sv -----
// ============================================================================
// dtcsl_apb_regs - APB configuration registers
// Holds gain, indicator threshold and change tolerance; zero-wait reads.
// ============================================================================
`default_nettype none

module dtcsl_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dtcsl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dtcsl_pkg::PDATA_W-1:0] pwdata,
    output logic      [dtcsl_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output dtcsl_pkg::t_cfg                    o_cfg
);
    import dtcsl_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tvb_gain            <= GAIN_RST;
            r_cfg.indicator_threshold <= THR_RST;
            r_cfg.change_tolerance    <= TOL_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TVB_GAIN:   r_cfg.tvb_gain            <= pwdata[GAIN_W-1:0];
                REG_IND_THRESH: r_cfg.indicator_threshold <= pwdata[THR_W-1:0];
                REG_CHG_TOL:    r_cfg.change_tolerance    <= pwdata[TOL_W-1:0];
                default: ;  // unmapped slot, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TVB_GAIN:   prdata = PDATA_W'(r_cfg.tvb_gain);
            REG_IND_THRESH: prdata = PDATA_W'(r_cfg.indicator_threshold);
            REG_CHG_TOL:    prdata = PDATA_W'(r_cfg.change_tolerance);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/dg_troubled_cell_slope_limiter.sv -----
// ============================================================================
// dg_troubled_cell_slope_limiter - troubled-cell indicator and minmod limiter
// Third-order DG, one cell plus neighbors per item, Q16.16 throughout.
// ============================================================================
// Throughput: one item per cycle; busy is tied low, the seven-stage pipeline
//   takes a new item every cycle and the receiver never stalls it.
// Reset: synchronous, active low; clears the stage valid bits and loads the
//   register reset values. No clearing pass, the block is ready right away.
// ============================================================================
`default_nettype none

module dg_troubled_cell_slope_limiter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire dtcsl_pkg::t_in_item           i_item,
    output logic                               o_valid,
    output dtcsl_pkg::t_out_item               o_result,
    // APB configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dtcsl_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dtcsl_pkg::PDATA_W-1:0] pwdata,
    output logic      [dtcsl_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);
    import dtcsl_pkg::*;

    t_cfg cfg;

    dtcsl_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Pipeline never back-pressures.
    assign busy = 1'b0;

    function automatic logic [31:0] abs32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : 32'(x);
    endfunction

    // ------------------------------------------------------------------
    // Valid bits, one per stage
    // ------------------------------------------------------------------
    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            r1_v <= start & ~busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitudes and signs of the words that get scaled,
    // neighbor mean differences, largest absolute mean.
    // ------------------------------------------------------------------
    logic signed [31:0] r1_lm, r1_rm, r1_cm, r1_cs, r1_cc;
    logic        [31:0] r1_mag_ls, r1_mag_lc, r1_mag_rs, r1_mag_rc;
    logic               r1_neg_ls, r1_neg_lc, r1_neg_rs, r1_neg_rc;
    logic        [32:0] r1_mag_dl, r1_mag_dr;
    logic               r1_neg_dl, r1_neg_dr;
    logic        [31:0] r1_max;

    logic signed [32:0] n_dl, n_dr;
    logic        [31:0] n_am_l, n_am_c, n_am_r, n_max_lc;

    always_comb begin
        n_dl = $signed({i_item.cell_mean[31], i_item.cell_mean})
             - $signed({i_item.left_mean[31], i_item.left_mean});
        n_dr = $signed({i_item.right_mean[31], i_item.right_mean})
             - $signed({i_item.cell_mean[31], i_item.cell_mean});
        n_am_l   = abs32(i_item.left_mean);
        n_am_c   = abs32(i_item.cell_mean);
        n_am_r   = abs32(i_item.right_mean);
        n_max_lc = (n_am_l > n_am_c) ? n_am_l : n_am_c;
    end

    always_ff @(posedge i_clk) begin
        r1_lm     <= i_item.left_mean;
        r1_rm     <= i_item.right_mean;
        r1_cm     <= i_item.cell_mean;
        r1_cs     <= i_item.cell_slope;
        r1_cc     <= i_item.cell_curv;
        r1_mag_ls <= abs32(i_item.left_slope);
        r1_mag_lc <= abs32(i_item.left_curv);
        r1_mag_rs <= abs32(i_item.right_slope);
        r1_mag_rc <= abs32(i_item.right_curv);
        r1_neg_ls <= i_item.left_slope[31];
        r1_neg_lc <= i_item.left_curv[31];
        r1_neg_rs <= i_item.right_slope[31];
        r1_neg_rc <= i_item.right_curv[31];
        r1_mag_dl <= n_dl[32] ? 33'(-n_dl) : 33'(n_dl);
        r1_mag_dr <= n_dr[32] ? 33'(-n_dr) : 33'(n_dr);
        r1_neg_dl <= n_dl[32];
        r1_neg_dr <= n_dr[32];
        r1_max    <= (n_max_lc > n_am_r) ? n_max_lc : n_am_r;
    end

    // ------------------------------------------------------------------
    // Stage 2: all first-level products, magnitude times a constant or a configured gain or threshold.
    // ------------------------------------------------------------------
    logic signed [31:0] r2_lm, r2_rm, r2_cm, r2_cs, r2_cc;
    logic        [63:0] r2_p_ls, r2_p_lc, r2_p_rs, r2_p_rc;
    logic               r2_neg_ls, r2_neg_lc, r2_neg_rs, r2_neg_rc;
    logic        [53:0] r2_p_dl, r2_p_dr;
    logic               r2_neg_dl, r2_neg_dr;
    logic        [48:0] r2_p_th;

    always_ff @(posedge i_clk) begin
        r2_lm     <= r1_lm;
        r2_rm     <= r1_rm;
        r2_cm     <= r1_cm;
        r2_cs     <= r1_cs;
        r2_cc     <= r1_cc;
        r2_p_ls   <= 64'(r1_mag_ls) * 64'(K_TWO_SQRT3);
        r2_p_lc   <= 64'(r1_mag_lc) * 64'(K_FIVE_SQRT5_3);
        r2_p_rs   <= 64'(r1_mag_rs) * 64'(K_TWO_SQRT3);
        r2_p_rc   <= 64'(r1_mag_rc) * 64'(K_FIVE_SQRT5_3);
        r2_neg_ls <= r1_neg_ls;
        r2_neg_lc <= r1_neg_lc;
        r2_neg_rs <= r1_neg_rs;
        r2_neg_rc <= r1_neg_rc;
        r2_p_dl   <= 54'(r1_mag_dl) * 54'(cfg.tvb_gain);
        r2_p_dr   <= 54'(r1_mag_dr) * 54'(cfg.tvb_gain);
        r2_neg_dl <= r1_neg_dl;
        r2_neg_dr <= r1_neg_dr;
        r2_p_th   <= 49'(cfg.indicator_threshold) * 49'(r1_max);
    end

    // ------------------------------------------------------------------
    // Stage 3: round half away from zero, restore signs, cap the scaled
    // differences, indicator bound = floor(T*M / 2^16).
    // ------------------------------------------------------------------
    localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;
    localparam logic [53:0] HALF_Q16 = 54'h8000;
    localparam logic [37:0] CAP_38   = 38'h01_0000_0000;

    logic signed [31:0] r3_lm, r3_rm, r3_cm, r3_cs, r3_cc;
    logic signed [34:0] r3_t_ls, r3_t_lc, r3_t_rs, r3_t_rc;
    logic        [32:0] r3_mb, r3_mc;
    logic               r3_nb, r3_nc;
    logic        [32:0] r3_bound;

    logic [63:0] n_s_ls, n_s_lc, n_s_rs, n_s_rc;
    logic [33:0] n_r_ls, n_r_lc, n_r_rs, n_r_rc;
    logic [53:0] n_s_dl, n_s_dr;
    logic [37:0] n_r_dl, n_r_dr;

    always_comb begin
        n_s_ls = r2_p_ls + HALF_Q30;
        n_s_lc = r2_p_lc + HALF_Q30;
        n_s_rs = r2_p_rs + HALF_Q30;
        n_s_rc = r2_p_rc + HALF_Q30;
        n_r_ls = n_s_ls[63:30];
        n_r_lc = n_s_lc[63:30];
        n_r_rs = n_s_rs[63:30];
        n_r_rc = n_s_rc[63:30];
        n_s_dl = r2_p_dl + HALF_Q16;
        n_s_dr = r2_p_dr + HALF_Q16;
        n_r_dl = n_s_dl[53:16];
        n_r_dr = n_s_dr[53:16];
    end

    always_ff @(posedge i_clk) begin
        r3_lm    <= r2_lm;
        r3_rm    <= r2_rm;
        r3_cm    <= r2_cm;
        r3_cs    <= r2_cs;
        r3_cc    <= r2_cc;
        // left side adds the slope term, right side subtracts it
        r3_t_ls  <= r2_neg_ls ? -$signed({1'b0, n_r_ls}) : $signed({1'b0, n_r_ls});
        r3_t_lc  <= r2_neg_lc ? -$signed({1'b0, n_r_lc}) : $signed({1'b0, n_r_lc});
        r3_t_rs  <= r2_neg_rs ? $signed({1'b0, n_r_rs}) : -$signed({1'b0, n_r_rs});
        r3_t_rc  <= r2_neg_rc ? -$signed({1'b0, n_r_rc}) : $signed({1'b0, n_r_rc});
        // a difference that rounds to zero counts as positive
        r3_nb    <= r2_neg_dl & (n_r_dl != '0);
        r3_nc    <= r2_neg_dr & (n_r_dr != '0);
        r3_mb    <= (n_r_dl > CAP_38) ? CAP_38[32:0] : n_r_dl[32:0];
        r3_mc    <= (n_r_dr > CAP_38) ? CAP_38[32:0] : n_r_dr[32:0];
        r3_bound <= r2_p_th[48:16];
    end

    // ------------------------------------------------------------------
    // Stage 4: extended neighbor means, 1/sqrt(3) products.
    // ------------------------------------------------------------------
    logic signed [31:0] r4_cm, r4_cs, r4_cc;
    logic signed [35:0] r4_ext_l, r4_ext_r;
    logic        [62:0] r4_q_b, r4_q_c;
    logic               r4_nb, r4_nc;
    logic        [32:0] r4_bound;

    always_ff @(posedge i_clk) begin
        r4_cm    <= r3_cm;
        r4_cs    <= r3_cs;
        r4_cc    <= r3_cc;
        r4_ext_l <= $signed({{4{r3_lm[31]}}, r3_lm})
                  + $signed({r3_t_ls[34], r3_t_ls})
                  + $signed({r3_t_lc[34], r3_t_lc});
        r4_ext_r <= $signed({{4{r3_rm[31]}}, r3_rm})
                  + $signed({r3_t_rs[34], r3_t_rs})
                  + $signed({r3_t_rc[34], r3_t_rc});
        r4_q_b   <= 63'(r3_mb) * 63'(K_INV_SQRT3);
        r4_q_c   <= 63'(r3_mc) * 63'(K_INV_SQRT3);
        r4_nb    <= r3_nb;
        r4_nc    <= r3_nc;
        r4_bound <= r3_bound;
    end

    // ------------------------------------------------------------------
    // Stage 5: jumps against the cell mean, round the 1/sqrt(3) products.
    // ------------------------------------------------------------------
    localparam logic [62:0] HALF_Q30_63 = 63'h2000_0000;

    logic signed [31:0] r5_cs, r5_cc;
    logic signed [36:0] r5_jl, r5_jr;
    logic        [31:0] r5_mb, r5_mc;
    logic               r5_nb, r5_nc;
    logic        [32:0] r5_bound;

    logic [62:0] n_s_b, n_s_c;

    always_comb begin
        n_s_b = r4_q_b + HALF_Q30_63;
        n_s_c = r4_q_c + HALF_Q30_63;
    end

    always_ff @(posedge i_clk) begin
        r5_cs    <= r4_cs;
        r5_cc    <= r4_cc;
        r5_jl    <= $signed({{5{r4_cm[31]}}, r4_cm}) - $signed({r4_ext_l[35], r4_ext_l});
        r5_jr    <= $signed({{5{r4_cm[31]}}, r4_cm}) - $signed({r4_ext_r[35], r4_ext_r});
        r5_mb    <= n_s_b[61:30];   // below 2^32 after the cap
        r5_mc    <= n_s_c[61:30];
        r5_nb    <= r4_nb;
        r5_nc    <= r4_nc;
        r5_bound <= r4_bound;
    end

    // ------------------------------------------------------------------
    // Stage 6: indicator sum, minmod slope.
    // ------------------------------------------------------------------
    logic signed [31:0] r6_cs, r6_cc;
    logic        [37:0] r6_sum;
    logic signed [32:0] r6_w1t;
    logic        [32:0] r6_bound;

    logic [36:0]        n_aj_l, n_aj_r;
    logic [31:0]        n_acs, n_min_bc, n_min;
    logic               n_na, n_same;
    logic signed [32:0] n_w1t;

    always_comb begin
        n_aj_l   = r5_jl[36] ? 37'(-r5_jl) : 37'(r5_jl);
        n_aj_r   = r5_jr[36] ? 37'(-r5_jr) : 37'(r5_jr);
        n_acs    = abs32(r5_cs);
        n_min_bc = (r5_mb < r5_mc) ? r5_mb : r5_mc;
        n_min    = (n_acs < n_min_bc) ? n_acs : n_min_bc;
        n_na     = r5_cs[31];
        n_same   = (n_na == r5_nb) && (n_na == r5_nc);
        if (!n_same) begin
            n_w1t = '0;
        end else if (n_na) begin
            n_w1t = -$signed({1'b0, n_min});
        end else begin
            n_w1t = $signed({1'b0, n_min});
        end
    end

    always_ff @(posedge i_clk) begin
        r6_cs    <= r5_cs;
        r6_cc    <= r5_cc;
        r6_sum   <= {1'b0, n_aj_l} + {1'b0, n_aj_r};
        r6_w1t   <= n_w1t;
        r6_bound <= r5_bound;
    end

    // ------------------------------------------------------------------
    // Stage 7: troubled test, change test, output register.
    // ------------------------------------------------------------------
    t_out_item          r7_res;
    logic signed [33:0] n_dd;
    logic        [33:0] n_add;
    logic               n_troubled, n_limited;

    always_comb begin
        n_troubled = r6_sum > {5'b0, r6_bound};
        n_dd       = $signed({{2{r6_cs[31]}}, r6_cs}) - $signed({r6_w1t[32], r6_w1t});
        n_add      = n_dd[33] ? 34'(-n_dd) : 34'(n_dd);
        n_limited  = n_troubled && (n_add > 34'(cfg.change_tolerance));
    end

    always_ff @(posedge i_clk) begin
        r7_res.troubled  <= n_troubled;
        r7_res.limited   <= n_limited;
        r7_res.slope_out <= n_limited ? r6_w1t[31:0] : r6_cs;
        r7_res.curv_out  <= n_limited ? '0 : r6_cc;
    end

    assign o_valid  = r7_v;
    assign o_result = r7_res;

endmodule

`default_nettype wire
